### rtl/jtvp_pkg.sv
package jtvp_pkg;

  localparam int BUFFER_BYTES_DEF = 512;
  localparam int PAD_PERIOD_DEF   = 32;
  localparam int MAX_RESULTS      = 3;
  localparam int COUNT_W          = 11;

  localparam logic [15:0] RESET_WORD_A = 16'h08C0;
  localparam logic [15:0] RESET_WORD_B = 16'h0FF0;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    REQ_STEP  = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_RESET = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       tms;
    logic       tdi;
    logic       keep_tms;
    logic       keep_tdi;
    logic       rd;
    logic       wr;
    logic       first_bit;
    logic       last_bit;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        data_word;
    logic [COUNT_W-1:0] tick_count;
    logic [COUNT_W-1:0] read_count;
    logic               overflow;
    logic               last;
  } out_t;

  // Results of one request; entry 0 goes out first.
  typedef struct packed {
    logic [1:0]                 count;
    out_t [MAX_RESULTS-1:0]     res;
  } bundle_t;

  // One tick in slot s: TDI in bit s, TMS in 4+s, write strobe in 8+s, read strobe in 12+s.
  function automatic logic [15:0] tick_bits(input logic [1:0] slot, input logic tms,
                                            input logic tdi, input logic rd,
                                            input logic wr);
    logic [3:0] bit_sel;
    bit_sel = 4'b0001 << slot;
    return {rd ? bit_sel : 4'b0000, wr ? bit_sel : 4'b0000,
            tms ? bit_sel : 4'b0000, tdi ? bit_sel : 4'b0000};
  endfunction

  function automatic out_t mk_word(input logic [15:0] word, input logic last);
    out_t r;
    r            = '0;
    r.kind       = KIND_DATA;
    r.data_word  = word;
    r.last       = last;
    return r;
  endfunction

  function automatic out_t mk_summary(input logic [COUNT_W-1:0] tc,
                                      input logic [COUNT_W-1:0] rc,
                                      input logic ov, input logic last);
    out_t r;
    r            = '0;
    r.kind       = KIND_SUMMARY;
    r.tick_count = tc;
    r.read_count = rc;
    r.overflow   = ov;
    r.last       = last;
    return r;
  endfunction

endpackage

### rtl/jtag_tick_vector_packer.sv
// JTAG tick packer: turns tick, scan-bit, flush and reset requests into 16-bit cable
// words of four ticks each, plus a tick/read summary on flush.
// Input channel in_valid/in_ready/in_data carries one request; output channel
// out_valid/out_ready/out_data carries one result (data word or summary) per transfer,
// and the last result of a request has out_data.last set. A request may give no result
// (a tick that leaves its group open), one, two (flush) or up to three (reset sequence).
// The first result of a request shows on out_valid once the request has passed the input
// register and then been loaded into the result register.
// Throughput: one request per cycle while each gives at most one result and out_ready
// stays high; a request with more results holds the result register until its last
// result is taken, since the output side moves one result per cycle while out_ready is
// high. The input register can take a request while a result waits.
// When the receiver stalls, the result register holds and the input register fills, then
// in_ready falls. A synchronous reset (rst_n low) empties both registers and clears the
// packing state, the counters and the held TMS/TDI levels.
module jtag_tick_vector_packer #(
  parameter int BUFFER_BYTES = jtvp_pkg::BUFFER_BYTES_DEF,
  parameter int PAD_PERIOD   = jtvp_pkg::PAD_PERIOD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  jtvp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jtvp_pkg::out_t out_data
);
  import jtvp_pkg::*;

  logic    item_valid;
  in_t     item;
  logic    free;
  logic    fire;
  bundle_t bundle;

  assign fire = item_valid && free;

  jtvp_stage u_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  jtvp_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .PAD_PERIOD   (PAD_PERIOD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .bundle (bundle)
  );

  jtvp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .bundle    (bundle),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/jtvp_core.sv
module jtvp_core #(
  parameter int BUFFER_BYTES = jtvp_pkg::BUFFER_BYTES_DEF,
  parameter int PAD_PERIOD   = jtvp_pkg::PAD_PERIOD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  jtvp_pkg::in_t     item,
  output jtvp_pkg::bundle_t bundle
);
  import jtvp_pkg::*;

  localparam int TICK_CAP = 2 * BUFFER_BYTES;
  localparam int CW       = $clog2(TICK_CAP + 1);
  localparam int PW       = $clog2(PAD_PERIOD);

  logic [15:0]   word_r,  word_nxt;
  logic [1:0]    slot_r,  slot_nxt;
  logic          tms_r,   tms_nxt;
  logic          tdi_r,   tdi_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [CW-1:0] ticks_r, ticks_nxt;
  logic [CW-1:0] reads_r, reads_nxt;
  logic          ovf_r,   ovf_nxt;

  logic [3:0]    add_k;
  logic          add_rd;
  logic          count_en;
  logic [CW:0]   tick_sum;
  logic [15:0]   word_t;
  logic [PW-1:0] phase_eff;
  logic          pad;
  logic          tick_tms;
  logic          tick_tdi;
  logic [3:0]    pad_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      slot_r  <= '0;
      tms_r   <= 1'b0;
      tdi_r   <= 1'b0;
      phase_r <= '0;
      ticks_r <= '0;
      reads_r <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      word_r  <= word_nxt;
      slot_r  <= slot_nxt;
      tms_r   <= tms_nxt;
      tdi_r   <= tdi_nxt;
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      reads_r <= reads_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    word_nxt  = word_r;
    slot_nxt  = slot_r;
    tms_nxt   = tms_r;
    tdi_nxt   = tdi_r;
    phase_nxt = phase_r;
    add_k     = 4'd0;
    add_rd    = 1'b0;
    count_en  = 1'b1;
    bundle    = '0;
    word_t    = word_r;
    phase_eff = item.first_bit ? '0 : phase_r;
    pad       = 1'b0;
    tick_tms  = 1'b0;
    tick_tdi  = 1'b0;
    pad_mask  = 4'b0111 & (4'b1111 << slot_r);

    unique case (req_t'(item.req_type))
      REQ_STEP, REQ_SCAN: begin
        if (req_t'(item.req_type) == REQ_STEP) begin
          tick_tms = item.keep_tms ? tms_r : item.tms;
          tick_tdi = item.keep_tdi ? tdi_r : item.tdi;
        end else begin
          tick_tms  = item.last_bit;
          tick_tdi  = item.tdi;
          pad       = item.rd && (phase_eff == PW'(PAD_PERIOD - 1) || item.last_bit);
          phase_nxt = (phase_eff == PW'(PAD_PERIOD - 1)) ? '0 : phase_eff + 1'b1;
        end
        tms_nxt = tick_tms;
        tdi_nxt = tick_tdi;
        add_rd  = item.rd;
        if (pad) begin
          // Pad ticks (TDI high only) fill the group up to slot 2; the bit lands in slot 3.
          word_t = word_r | {12'h000, pad_mask}
                   | tick_bits(2'd3, tick_tms, tick_tdi, item.rd, item.wr);
          add_k  = 4'd4 - {2'b00, slot_r};
        end else begin
          word_t = word_r | tick_bits(slot_r, tick_tms, tick_tdi, item.rd, item.wr);
          add_k  = 4'd1;
        end
        if (pad || slot_r == 2'd3) begin
          bundle.count  = 2'd1;
          bundle.res[0] = mk_word(word_t, 1'b1);
          word_nxt      = '0;
          slot_nxt      = '0;
        end else begin
          word_nxt = word_t;
          slot_nxt = slot_r + 2'd1;
        end
      end
      REQ_FLUSH: begin
        count_en = 1'b0;
        if (slot_r != 2'd0) begin
          bundle.count  = 2'd2;
          bundle.res[0] = mk_word(word_r, 1'b0);
          bundle.res[1] = mk_summary(COUNT_W'(ticks_r), COUNT_W'(reads_r), ovf_r, 1'b1);
        end else begin
          bundle.count  = 2'd1;
          bundle.res[0] = mk_summary(COUNT_W'(ticks_r), COUNT_W'(reads_r), ovf_r, 1'b1);
        end
        word_nxt = '0;
        slot_nxt = '0;
      end
      REQ_RESET: begin
        // The unused slots of an open group are counted so the tick total stays whole.
        if (slot_r != 2'd0) begin
          bundle.count  = 2'd3;
          bundle.res[0] = mk_word(word_r, 1'b0);
          bundle.res[1] = mk_word(RESET_WORD_A, 1'b0);
          bundle.res[2] = mk_word(RESET_WORD_B, 1'b1);
          add_k         = 4'd12 - {2'b00, slot_r};
        end else begin
          bundle.count  = 2'd2;
          bundle.res[0] = mk_word(RESET_WORD_A, 1'b0);
          bundle.res[1] = mk_word(RESET_WORD_B, 1'b1);
          add_k         = 4'd8;
        end
        word_nxt = '0;
        slot_nxt = '0;
      end
      default: begin
        count_en = 1'b1;
      end
    endcase

    tick_sum = {1'b0, ticks_r} + (CW + 1)'(add_k);
    if (!count_en) begin
      ticks_nxt = '0;
      reads_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      if (tick_sum > (CW + 1)'(TICK_CAP)) begin
        ticks_nxt = CW'(TICK_CAP);
        ovf_nxt   = 1'b1;
      end else begin
        ticks_nxt = tick_sum[CW-1:0];
        ovf_nxt   = ovf_r;
      end
      if (add_rd && reads_r < CW'(TICK_CAP)) begin
        reads_nxt = reads_r + 1'b1;
      end else begin
        reads_nxt = reads_r;
      end
    end
  end

endmodule

### rtl/jtvp_emit.sv
module jtvp_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jtvp_pkg::bundle_t bundle,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output jtvp_pkg::out_t    out_data
);
  import jtvp_pkg::*;

  bundle_t    bnd_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       on_last;

  assign on_last   = (idx_r == bnd_r.count - 2'd1);
  assign free      = !valid_r || (out_ready && on_last);
  assign out_valid = valid_r;
  assign out_data  = bnd_r.res[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= (bundle.count != 2'd0);
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (on_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bundle;
    end
  end

endmodule

### rtl/jtvp_top_placeholder.sv
module jtvp_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jtvp_pkg::in_t in_data,
  input  logic          take,
  output logic          item_valid,
  output jtvp_pkg::in_t item
);
  import jtvp_pkg::*;

  logic valid_r;
  in_t  item_r;

  assign item_valid = valid_r;
  assign item       = item_r;
  assign in_ready   = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

### test/jtag_tick_vector_packer_test.sv
`timescale 1ns / 100ps

module jtag_tick_vector_packer_test;
  import jtvp_pkg::*;

  localparam int TICK_CAP = 2 * BUFFER_BYTES_DEF;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  jtag_tick_vector_packer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Packing state of the predictor.
  logic [15:0] grp_word;
  logic [1:0]  grp_slot;
  bit          hold_tms;
  bit          hold_tdi;
  int          scan_phase;
  int          n_ticks;
  int          n_reads;
  bit          ovf;

  out_t words_of_request[$];
  out_t pending_words[$];
  out_t want;
  int   errors;
  int   items_done;
  int   burst_left;
  bit   pressure_done;

  typedef struct {
    in_t  req;
    bit   typed;
    int   n;
    out_t res[3];
  } row_t;

  row_t plan[$];

  function automatic in_t mk_in(req_t req, bit tms, bit tdi, bit keep_tms, bit keep_tdi,
                                bit rd, bit wr, bit first_bit, bit last_bit);
    in_t r;
    r.req_type  = req;
    r.tms       = tms;
    r.tdi       = tdi;
    r.keep_tms  = keep_tms;
    r.keep_tdi  = keep_tdi;
    r.rd        = rd;
    r.wr        = wr;
    r.first_bit = first_bit;
    r.last_bit  = last_bit;
    return r;
  endfunction

  function automatic out_t word_res(logic [15:0] w, bit last);
    out_t r;
    r           = '0;
    r.kind      = KIND_DATA;
    r.data_word = w;
    r.last      = last;
    return r;
  endfunction

  function automatic out_t summary_res(int tc, int rc, bit ov, bit last);
    out_t r;
    r            = '0;
    r.kind       = KIND_SUMMARY;
    r.tick_count = COUNT_W'(tc);
    r.read_count = COUNT_W'(rc);
    r.overflow   = ov;
    r.last       = last;
    return r;
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function void count_ticks(int k);
    if (n_ticks + k > TICK_CAP) begin
      n_ticks = TICK_CAP;
      ovf     = 1'b1;
    end else begin
      n_ticks += k;
    end
  endfunction

  function void place_tick(bit tms, bit tdi, bit rd, bit wr);
    logic [3:0] sel;
    sel = 4'b0001 << grp_slot;
    if (tdi) grp_word[3:0]   |= sel;
    if (tms) grp_word[7:4]   |= sel;
    if (wr)  grp_word[11:8]  |= sel;
    if (rd)  grp_word[15:12] |= sel;
    count_ticks(1);
    if (rd && n_reads < TICK_CAP) n_reads++;
    grp_slot = grp_slot + 2'd1;
    if (grp_slot == 2'd0) begin
      words_of_request.push_back(word_res(grp_word, 1'b0));
      grp_word = '0;
    end
  endfunction

  // Works out the cable words and summary that one request produces.
  function void pack_request(in_t r);
    words_of_request.delete();
    case (req_t'(r.req_type))
      REQ_STEP: begin
        if (!r.keep_tms) hold_tms = r.tms;
        if (!r.keep_tdi) hold_tdi = r.tdi;
        place_tick(hold_tms, hold_tdi, r.rd, r.wr);
      end
      REQ_SCAN: begin
        if (r.first_bit) scan_phase = 0;
        // Read scans pad until the bit that must land in slot 3 does.
        while (r.rd && (scan_phase == PAD_PERIOD_DEF - 1 || r.last_bit) &&
               grp_slot != 2'd3) begin
          hold_tms = 1'b0;
          hold_tdi = 1'b1;
          place_tick(1'b0, 1'b1, 1'b0, 1'b0);
        end
        hold_tms = r.last_bit;
        hold_tdi = r.tdi;
        place_tick(r.last_bit, r.tdi, r.rd, r.wr);
        scan_phase++;
        if (scan_phase >= PAD_PERIOD_DEF) scan_phase = 0;
      end
      REQ_FLUSH: begin
        if (grp_slot != 2'd0) words_of_request.push_back(word_res(grp_word, 1'b0));
        words_of_request.push_back(summary_res(n_ticks, n_reads, ovf, 1'b0));
        grp_word = '0;
        grp_slot = '0;
        n_ticks  = 0;
        n_reads  = 0;
        ovf      = 1'b0;
      end
      default: begin
        // The open group is closed zero-filled and its empty slots still count.
        if (grp_slot != 2'd0) begin
          words_of_request.push_back(word_res(grp_word, 1'b0));
          count_ticks(4 - int'(grp_slot));
          grp_word = '0;
          grp_slot = '0;
        end
        words_of_request.push_back(word_res(RESET_WORD_A, 1'b0));
        words_of_request.push_back(word_res(RESET_WORD_B, 1'b0));
        count_ticks(8);
      end
    endcase
    if (words_of_request.size() > 0) words_of_request[$].last = 1'b1;
  endfunction

  function void add_row(in_t req, bit typed = 1'b0, int n = 0, out_t e0 = '0,
                        out_t e1 = '0, out_t e2 = '0);
    row_t x;
    x.req    = req;
    x.typed  = typed;
    x.n      = n;
    x.res[0] = e0;
    x.res[1] = e1;
    x.res[2] = e2;
    plan.push_back(x);
  endfunction

  // Mostly no gap or a short one, a few long ones, and now and then a run with none.
  function int sender_gap();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 10) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(in_t r, bit typed = 1'b0, int n = 0, out_t e0 = '0,
                           out_t e1 = '0, out_t e2 = '0);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pack_request(r);
    if (typed) begin
      if (n > 0) pending_words.push_back(e0);
      if (n > 1) pending_words.push_back(e1);
      if (n > 2) pending_words.push_back(e2);
    end else begin
      foreach (words_of_request[i]) pending_words.push_back(words_of_request[i]);
    end
    items_done++;
  endtask

  // Receiver: random stalls, with one long hold-off while requests keep coming.
  initial begin
    int p;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!pressure_done && items_done >= 30) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 50) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (p < 85) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (p < 95) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: result with none expected: kind=%0d word=%h tc=%0d rc=%0d ov=%0d last=%0d",
                 $time, out_data.kind, out_data.data_word, out_data.tick_count,
                 out_data.read_count, out_data.overflow, out_data.last);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch: expected kind=%0d word=%h tc=%0d rc=%0d ov=%0d last=%0d",
                   $time, want.kind, want.data_word, want.tick_count, want.read_count,
                   want.overflow, want.last);
          $display("%0t:           actual kind=%0d word=%h tc=%0d rc=%0d ov=%0d last=%0d",
                   $time, out_data.kind, out_data.data_word, out_data.tick_count,
                   out_data.read_count, out_data.overflow, out_data.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("jtag_tick_vector_packer_test: FAIL");
    $finish;
  end

  initial begin
    int         p;
    int         len;
    bit         scan_rd;
    logic [9:0] raw;
    in_t        flush_req;
    in_t        ones_step;

    errors     = 0;
    items_done = 0;
    burst_left = 0;
    grp_word   = '0;
    grp_slot   = '0;
    hold_tms   = 1'b0;
    hold_tdi   = 1'b0;
    scan_phase = 0;
    n_ticks    = 0;
    n_reads    = 0;
    ovf        = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    flush_req = mk_in(REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0);
    ones_step = mk_in(REQ_STEP, 1, 1, 0, 0, 1, 1, 0, 0);
    add_row(flush_req, 1, 1, summary_res(0, 0, 1'b0, 1'b1));
    add_row(mk_in(REQ_RESET, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2,
            word_res(RESET_WORD_A, 1'b0), word_res(RESET_WORD_B, 1'b1));
    add_row(flush_req, 1, 1, summary_res(8, 0, 1'b0, 1'b1));
    repeat (3) add_row(ones_step, 1, 0);
    add_row(ones_step, 1, 1, word_res(16'hFFFF, 1'b1));
    add_row(flush_req, 1, 1, summary_res(4, 4, 1'b0, 1'b1));
    add_row(mk_in(REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(REQ_STEP, 1, 1, 1, 1, 0, 1, 0, 0));
    add_row(mk_in(REQ_STEP, 1, 0, 0, 1, 1, 0, 0, 0));
    add_row(flush_req);
    add_row(mk_in(REQ_SCAN, 0, 1, 0, 0, 1, 1, 1, 0));
    // Keep bits are ignored on a scan bit; the last bit pads up to slot 3.
    add_row(mk_in(REQ_SCAN, 1, 0, 1, 1, 1, 0, 0, 1));
    add_row(mk_in(REQ_SCAN, 0, 1, 0, 0, 0, 1, 1, 1));
    add_row(mk_in(REQ_STEP, 0, 1, 0, 0, 0, 1, 0, 0));
    add_row(mk_in(REQ_RESET, 1, 1, 1, 1, 1, 1, 1, 1));
    add_row(mk_in(REQ_SCAN, 0, 0, 0, 0, 1, 1, 1, 1));
    add_row(mk_in(REQ_FLUSH, 1, 1, 1, 1, 1, 1, 1, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k])
      send_item(plan[k].req, plan[k].typed, plan[k].n, plan[k].res[0], plan[k].res[1],
                plan[k].res[2]);

    while (items_done < 140) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(31, 40) : $urandom_range(1, 10);
        scan_rd = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++)
          send_item(mk_in(REQ_SCAN, coin(), coin(), coin(), coin(),
                          scan_rd ^ ($urandom_range(0, 9) == 0), coin(), i == 0, i == len - 1));
      end else if (p < 75) begin
        repeat ($urandom_range(1, 8))
          send_item(mk_in(REQ_STEP, coin(), coin(), coin(), coin(), coin(), coin(),
                          coin(), coin()));
      end else if (p < 83) begin
        repeat ($urandom_range(1, 6))
          send_item(mk_in(REQ_SCAN, coin(), coin(), coin(), coin(), coin(), coin(),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
      end else if (p < 91) begin
        send_item(mk_in(REQ_FLUSH, coin(), coin(), coin(), coin(), coin(), coin(),
                        coin(), coin()));
      end else if (p < 96) begin
        send_item(mk_in(REQ_RESET, coin(), coin(), coin(), coin(), coin(), coin(),
                        coin(), coin()));
      end else begin
        raw = 10'($urandom);
        send_item(in_t'(raw));
      end
    end

    // A few reading steps and reset sequences from a clean start, then report the counts.
    send_item(flush_req);
    repeat (8)
      send_item(mk_in(REQ_STEP, coin(), coin(), coin(), coin(), 1, coin(), coin(), coin()));
    repeat (2) send_item(mk_in(REQ_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(flush_req);
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("jtag_tick_vector_packer_test: PASS");
    end else begin
      $display("jtag_tick_vector_packer_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jtvp_pkg.sv
rtl/jtvp_core.sv
rtl/jtvp_emit.sv
rtl/jtvp_top_placeholder.sv
rtl/jtag_tick_vector_packer.sv
test/jtag_tick_vector_packer_test.sv
